[src/gsp_pkg.sv]
package gsp_pkg;

   // one gain set as held in the csr: kp bits 15:0, ki 31:16, kd 47:32
   typedef struct packed {
      logic signed [15:0] kd;
      logic signed [15:0] ki;
      logic signed [15:0] kp;
   } gains_type;

   typedef enum logic [1:0] {
      MODE_LINE   = 2'd0,
      MODE_NORMAL = 2'd1,
      MODE_CIRCLE = 2'd2,
      MODE_HOLD   = 2'd3
   } gain_mode_type;

   localparam logic [1:0] CSR_GAIN_MODE    = 2'd0;
   localparam logic [1:0] CSR_GAINS_NORMAL = 2'd1;
   localparam logic [1:0] CSR_GAINS_LINE   = 2'd2;
   localparam logic [1:0] CSR_GAINS_CIRCLE = 2'd3;

   localparam logic REQ_STEP = 1'b0;
   localparam logic REQ_STOP = 1'b1;

   localparam int GAIN_WIDTH  = 48;
   localparam int ERROR_WIDTH = 16;
   localparam int DRIVE_WIDTH = 32;

   localparam logic [GAIN_WIDTH-1:0] GAINS_NORMAL_RESET = 48'd0;
   localparam logic [GAIN_WIDTH-1:0] GAINS_LINE_RESET   = 48'd5120;
   localparam logic [GAIN_WIDTH-1:0] GAINS_CIRCLE_RESET = 48'd38482906992640;

   localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_MAX = 32'sh7fff_ffff;
   localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_MIN = 32'sh8000_0000;

   // integral register width: holds +-(10 << frac_bits) plus one error sample
   function automatic int integ_width(input int frac_bits);
      int w;
      w = frac_bits + 6;
      if (w < 17) begin
         w = 17;
      end
      return w;
   endfunction

endpackage

[src/gsp_state.sv]
module gsp_state #(
   parameter int FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic                     req_type,
   input  logic signed [15:0]       error_sample,
   input  gsp_pkg::gain_mode_type   gain_mode,
   input  gsp_pkg::gains_type       gains_normal,
   input  gsp_pkg::gains_type       gains_line,
   input  gsp_pkg::gains_type       gains_circle,
   output logic                     op_stop,
   output logic signed [15:0]       op_error,
   output logic signed [16:0]       op_diff,
   output logic signed [gsp_pkg::integ_width(FRAC_BITS)-1:0] op_integral,
   output gsp_pkg::gains_type       op_gains
);
   import gsp_pkg::*;

   localparam int IntegWidth = integ_width(FRAC_BITS);
   localparam logic signed [IntegWidth:0] IntegHi = (IntegWidth+1)'(10 << FRAC_BITS);
   localparam logic signed [IntegWidth:0] IntegLo = (IntegWidth+1)'(9 << FRAC_BITS);

   logic signed [IntegWidth-1:0] integral_ff, integral_in;
   logic signed [15:0]           prev_error_ff, prev_error_in;
   gains_type                    active_gains_ff, active_gains_in;
   logic signed [IntegWidth:0]   integ_sum;
   gains_type                    gains_sel;

   // operand register, no reset
   logic                         op_stop_ff;
   logic signed [15:0]           op_error_ff;
   logic signed [16:0]           op_diff_ff;
   logic signed [IntegWidth-1:0] op_integral_ff;
   gains_type                    op_gains_ff;

   always_comb begin
      case (gain_mode)
         MODE_LINE:   gains_sel = gains_line;
         MODE_NORMAL: gains_sel = gains_normal;
         MODE_CIRCLE: gains_sel = gains_circle;
         default:     gains_sel = active_gains_ff;
      endcase
   end

   assign integ_sum = (IntegWidth+1)'(integral_ff) + (IntegWidth+1)'(error_sample);

   always_comb begin
      integral_in     = integral_ff;
      prev_error_in   = prev_error_ff;
      active_gains_in = active_gains_ff;
      if (load) begin
         if (req_type == REQ_STOP) begin
            prev_error_in = '0;
         end else begin
            prev_error_in   = error_sample;
            active_gains_in = gains_sel;
            if (integ_sum > IntegHi) begin
               integral_in = IntegWidth'(IntegLo);
            end else if (integ_sum < -IntegHi) begin
               integral_in = IntegWidth'(-IntegLo);
            end else begin
               integral_in = IntegWidth'(integ_sum);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff     <= '0;
         prev_error_ff   <= '0;
         active_gains_ff <= GAINS_NORMAL_RESET;
      end else begin
         integral_ff     <= integral_in;
         prev_error_ff   <= prev_error_in;
         active_gains_ff <= active_gains_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_stop_ff     <= (req_type == REQ_STOP);
         op_error_ff    <= error_sample;
         op_diff_ff     <= 17'(error_sample) - 17'(prev_error_ff);
         op_integral_ff <= integral_in;
         op_gains_ff    <= gains_sel;
      end
   end

   assign op_stop     = op_stop_ff;
   assign op_error    = op_error_ff;
   assign op_diff     = op_diff_ff;
   assign op_integral = op_integral_ff;
   assign op_gains    = op_gains_ff;

`ifndef NO_ASSERTIONS
   // a stop leaves the integral alone and zeroes the previous error
   a_stop_state: assert property (@(posedge clock) disable iff (reset)
      (load && req_type == REQ_STOP) |=> ($stable(integral_ff) && prev_error_ff == '0))
      else $error("stop transaction disturbed controller state");
`endif

endmodule

[src/gsp_datapath.sv]
module gsp_datapath #(
   parameter int FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     load,
   input  logic                     op_stop,
   input  logic signed [15:0]       op_error,
   input  logic signed [16:0]       op_diff,
   input  logic signed [gsp_pkg::integ_width(FRAC_BITS)-1:0] op_integral,
   input  gsp_pkg::gains_type       op_gains,
   output logic signed [31:0]       drive_value
);
   import gsp_pkg::*;

   localparam int IntegWidth = integ_width(FRAC_BITS);
   localparam int AccWidth   = 16 + IntegWidth + 2;
   localparam logic signed [AccWidth-1:0] AccMax = AccWidth'(DRIVE_MAX);
   localparam logic signed [AccWidth-1:0] AccMin = AccWidth'(DRIVE_MIN);

   logic signed [31:0]              prod_kp;
   logic signed [16+IntegWidth-1:0] prod_ki;
   logic signed [32:0]              prod_kd;
   logic signed [AccWidth-1:0]      acc;
   logic signed [AccWidth-1:0]      acc_shift;
   logic signed [31:0]              drive_sat;
   logic signed [31:0]              drive_ff, drive_in;

   assign prod_kp = 32'(op_gains.kp) * 32'(op_error);
   assign prod_ki = (16+IntegWidth)'(op_gains.ki) * (16+IntegWidth)'(op_integral);
   assign prod_kd = 33'(op_gains.kd) * 33'(op_diff);

   assign acc       = AccWidth'(prod_kp) + AccWidth'(prod_ki) + AccWidth'(prod_kd);
   // arithmetic shift rounds toward minus infinity
   assign acc_shift = acc >>> FRAC_BITS;

   always_comb begin
      if (acc_shift > AccMax) begin
         drive_sat = DRIVE_MAX;
      end else if (acc_shift < AccMin) begin
         drive_sat = DRIVE_MIN;
      end else begin
         drive_sat = 32'(acc_shift);
      end
      drive_in = op_stop ? '0 : drive_sat;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff <= drive_in;
      end
   end

   assign drive_value = drive_ff;

`ifndef NO_ASSERTIONS
   a_stop_zero: assert property (@(posedge clock)
      (load && op_stop) |=> (drive_ff == '0))
      else $error("stop transaction produced nonzero drive value");
`endif

endmodule

[src/gain_scheduled_pid.sv]
// gain_scheduled_pid: positional pid controller with clamped integral and
// three csr-selectable gain sets (line, normal, circle, or hold last set)
// request channel: req_valid/req_stall with req_type (0 step, 1 stop) and a
//   signed q8.8 req_error_sample; a transaction completes on valid & !stall
// response channel: rsp_valid/rsp_stall with a signed rsp_drive_value,
//   one response per request, in order
// csr port: csr_write_enable/csr_index/csr_write_data, to be written by the user only
//   while no transaction is in flight; the block itself does not enforce this
// path: a taken request loads the operand register, then moves on to the result
//   register once that is empty or being drained
// throughput: one transaction per cycle unless responses stall; the state
//   update (integral add and clamp) feeds three parallel multiplies and a sum
// stall: a stalled response holds; the operand stage keeps filling, so the
//   block stalls requests only when both stages hold data
// reset: synchronous, clears both valid flags, integral and previous error,
//   zeroes the active gains and loads the csr reset values
module gain_scheduled_pid #(
   parameter int FRAC_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic signed [15:0]  req_error_sample,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_drive_value,
   // csr write port
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [47:0]         csr_write_data
);
   import gsp_pkg::*;

   localparam int IntegWidth = integ_width(FRAC_BITS);

   // csr registers
   gain_mode_type gain_mode_ff, gain_mode_in;
   gains_type     gains_normal_ff, gains_normal_in;
   gains_type     gains_line_ff, gains_line_in;
   gains_type     gains_circle_ff, gains_circle_in;

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept;
   logic out_load;

   // operands between the two stages
   logic                         op_stop;
   logic signed [15:0]           op_error;
   logic signed [16:0]           op_diff;
   logic signed [IntegWidth-1:0] op_integral;
   gains_type                    op_gains;

   // csr writes, index beyond the list cannot occur with a 2-bit index
   always_comb begin
      gain_mode_in    = gain_mode_ff;
      gains_normal_in = gains_normal_ff;
      gains_line_in   = gains_line_ff;
      gains_circle_in = gains_circle_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_GAIN_MODE:    gain_mode_in    = gain_mode_type'(csr_write_data[1:0]);
            CSR_GAINS_NORMAL: gains_normal_in = csr_write_data;
            CSR_GAINS_LINE:   gains_line_in   = csr_write_data;
            CSR_GAINS_CIRCLE: gains_circle_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_mode_ff    <= MODE_NORMAL;
         gains_normal_ff <= GAINS_NORMAL_RESET;
         gains_line_ff   <= GAINS_LINE_RESET;
         gains_circle_ff <= GAINS_CIRCLE_RESET;
      end else begin
         gain_mode_ff    <= gain_mode_in;
         gains_normal_ff <= gains_normal_in;
         gains_line_ff   <= gains_line_in;
         gains_circle_ff <= gains_circle_in;
      end
   end

   // result register takes a full operand stage when empty or being drained
   assign out_load   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   // operand stage is free when empty or moving forward this cycle
   assign req_stall  = s1_valid_ff && !out_load;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !out_load);
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // state update and operand capture
   gsp_state #(
      .FRAC_BITS (FRAC_BITS)
   ) u_state (
      .clock        (clock),
      .reset        (reset),
      .load         (req_accept),
      .req_type     (req_type),
      .error_sample (req_error_sample),
      .gain_mode    (gain_mode_ff),
      .gains_normal (gains_normal_ff),
      .gains_line   (gains_line_ff),
      .gains_circle (gains_circle_ff),
      .op_stop      (op_stop),
      .op_error     (op_error),
      .op_diff      (op_diff),
      .op_integral  (op_integral),
      .op_gains     (op_gains)
   );

   // multiply, sum, scale, saturate (zero for a stop) into the result register
   gsp_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .load        (out_load),
      .op_stop     (op_stop),
      .op_error    (op_error),
      .op_diff     (op_diff),
      .op_integral (op_integral),
      .op_gains    (op_gains),
      .drive_value (rsp_drive_value)
   );

`ifndef NO_ASSERTIONS
   // requests are held off only with both stages occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with a free pipeline stage");

   // an operand moving forward must show up as a response
   a_advance: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("operand stage advanced but no response appeared");

   // a held response with a full operand stage keeps the operand
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=> s1_valid_ff)
      else $error("operand transaction dropped under stall");
`endif

endmodule

[tb/sv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gsp_pkg::*;

   // fixed-point format and integral clamp bounds of the controller
   localparam int FRAC_BITS    = 8;
   localparam int INTEG_LIMIT  = 10 << FRAC_BITS;
   localparam int INTEG_RELOAD = 9 << FRAC_BITS;

   // run shape
   localparam int RAND_PHASES  = 14;
   localparam int PHASE_ITEMS  = 100;
   localparam int HOLD_CYCLES  = 200;
   localparam int IDLE_CYCLES  = 3;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 10;
   localparam int TIMEOUT_NS   = 3_000_000;

   // clock and synchronous reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic                      req_type         = REQ_STEP;
   logic signed [15:0]        req_error_sample = '0;
   // response channel
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic signed [31:0]        rsp_drive_value;
   // csr write port
   logic                      csr_write_enable = 1'b0;
   logic [1:0]                csr_index        = CSR_GAIN_MODE;
   logic [GAIN_WIDTH-1:0]     csr_write_data   = '0;

   gain_scheduled_pid u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_error_sample (req_error_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_drive_value  (rsp_drive_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------
   // shadow copy of the csr file and of the controller state
   // ---------------------------------------------------------------
   gain_mode_type mode_sh   = MODE_NORMAL;
   gains_type     normal_sh = GAINS_NORMAL_RESET;
   gains_type     line_sh   = GAINS_LINE_RESET;
   gains_type     circle_sh = GAINS_CIRCLE_RESET;
   gains_type     active_sh = '0;   // all zero until the first step loads a set
   int            integ_sh  = 0;
   logic signed [15:0] prev_err_sh = '0;

   // expected drive values, oldest first
   logic signed [31:0] pending_drive [$];

   // bookkeeping
   int  fail_count    = 0;
   int  sent_count    = 0;
   int  stop_count    = 0;
   int  checked_count = 0;
   int  csr_count     = 0;
   int  clamp_hi      = 0;
   int  clamp_lo      = 0;
   int  hold_count    = 0;
   bit  calm          = 1'b0;   // no idling on either side while set
   bit  random_phase  = 1'b0;
   logic hold_rsp     = 1'b0;

   // one control step: gain selection, clamped integral, pid sum, floor and saturate
   function automatic logic signed [31:0] pid_step_drive(input logic rtype,
                                                         input logic signed [15:0] err);
      longint kp, ki, kd, e, acc;
      if (rtype == REQ_STOP) begin
         prev_err_sh = '0;
         return '0;
      end
      case (mode_sh)
         MODE_LINE:   active_sh = line_sh;
         MODE_NORMAL: active_sh = normal_sh;
         MODE_CIRCLE: active_sh = circle_sh;
         default:     ;   // hold keeps whatever was loaded last
      endcase
      kp = $signed(active_sh.kp);
      ki = $signed(active_sh.ki);
      kd = $signed(active_sh.kd);
      e  = err;
      integ_sh = integ_sh + err;
      if (integ_sh > INTEG_LIMIT) begin
         integ_sh = INTEG_RELOAD;
         clamp_hi++;
      end
      if (integ_sh < -INTEG_LIMIT) begin
         integ_sh = -INTEG_RELOAD;
         clamp_lo++;
      end
      acc = kp * e + ki * longint'(integ_sh) + kd * (e - longint'(prev_err_sh));
      prev_err_sh = err;
      // arithmetic shift rounds toward minus infinity
      acc = acc >>> FRAC_BITS;
      if (acc > longint'(DRIVE_MAX)) acc = DRIVE_MAX;
      if (acc < longint'(DRIVE_MIN)) acc = DRIVE_MIN;
      return 32'(acc);
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // one signed q8.8 gain: extremes, small values or anything
   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 6))
         0:       return 16'h7fff;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hffff;
         4, 5:    return 16'($urandom_range(0, 2047) - 1024);
         default: return 16'($urandom());
      endcase
   endfunction

   // error sample: small values walk the integral, large ones hit the clamp
   function automatic logic signed [15:0] pick_error(input int bias);
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 16'(int'($urandom_range(0, 800)) - 400 + bias);
      if (r < 60) return 16'(int'($urandom_range(0, 6000)) - 3000);
      if (r < 90) return 16'($urandom());
      case ($urandom_range(0, 4))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return 16'sd0;
         3:       return -16'sd1;
         default: return 16'sd1;
      endcase
   endfunction

   // offer one request transaction and hold it until taken
   task automatic send_req(input logic rtype, input logic signed [15:0] err,
                           input bit has_drive, input logic signed [31:0] table_drive);
      int gap;
      logic signed [31:0] predicted;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= rtype;
      req_error_sample <= err;
      do @(posedge clock); while (req_stall);
      // state always advances, the table value wins where one is given
      predicted = pid_step_drive(rtype, err);
      pending_drive.push_back(has_drive ? table_drive : predicted);
      sent_count++;
      if (rtype == REQ_STOP) stop_count++;
   endtask

   // csr write once the pipe has emptied
   task automatic write_csr(input logic [1:0] idx, input logic [GAIN_WIDTH-1:0] data);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_GAIN_MODE:    mode_sh   = gain_mode_type'(data[1:0]);
         CSR_GAINS_NORMAL: normal_sh = data;
         CSR_GAINS_LINE:   line_sh   = data;
         CSR_GAINS_CIRCLE: circle_sh = data;
         default:          ;
      endcase
      csr_count++;
   endtask

   // ---------------------------------------------------------------
   // directed table: csr rows or request rows, an expected drive value
   // typed in only where it is obvious
   // ---------------------------------------------------------------
   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic                   rtype;
      logic signed [15:0]     err;
      bit                     has_drive;
      logic signed [31:0]     drive;
      logic [1:0]             csr_idx;
      logic [GAIN_WIDTH-1:0]  csr_data;
   } dir_row_type;

   localparam int DIR_ROWS = 32;

   dir_row_type dir_table [DIR_ROWS] = '{
      // hold right after reset: active gains are all zero
      '{ROW_CSR, REQ_STEP, 16'sd0,     1'b0, 32'sd0,       CSR_GAIN_MODE, 48'(MODE_HOLD)},
      '{ROW_REQ, REQ_STEP, 16'sh7fff,  1'b1, 32'sd0,       CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STEP, 16'sh8000,  1'b1, 32'sd0,       CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STOP, 16'sh1234,  1'b1, 32'sd0,       CSR_GAIN_MODE, '0},
      // normal gains reset to zero
      '{ROW_CSR, REQ_STEP, 16'sd0,     1'b0, 32'sd0,       CSR_GAIN_MODE, 48'(MODE_NORMAL)},
      '{ROW_REQ, REQ_STEP, 16'sd1,     1'b1, 32'sd0,       CSR_GAIN_MODE, '0},
      // line gains reset to kp 20 only: drive is twenty times the error
      '{ROW_CSR, REQ_STEP, 16'sd0,     1'b0, 32'sd0,       CSR_GAIN_MODE, 48'(MODE_LINE)},
      '{ROW_REQ, REQ_STEP, 16'sh7fff,  1'b1, 32'sd655340,  CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STEP, 16'sh8000,  1'b1, -32'sd655360, CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STEP, -16'sd1,    1'b1, -32'sd20,     CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STEP, 16'sd0,     1'b1, 32'sd0,       CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STOP, 16'sh7fff,  1'b1, 32'sd0,       CSR_GAIN_MODE, '0},
      // hold keeps the line set
      '{ROW_CSR, REQ_STEP, 16'sd0,     1'b0, 32'sd0,       CSR_GAIN_MODE, 48'(MODE_HOLD)},
      '{ROW_REQ, REQ_STEP, 16'sd100,   1'b1, 32'sd2000,    CSR_GAIN_MODE, '0},
      // circle set: derivative against the previous error, cleared by stop
      '{ROW_CSR, REQ_STEP, 16'sd0,     1'b0, 32'sd0,       CSR_GAIN_MODE, 48'(MODE_CIRCLE)},
      '{ROW_REQ, REQ_STEP, 16'sd256,   1'b0, 32'sd0,       CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STEP, -16'sd256,  1'b0, 32'sd0,       CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STOP, 16'sd0,     1'b1, 32'sd0,       CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STEP, 16'sd300,   1'b0, 32'sd0,       CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STEP, 16'sh7fff,  1'b0, 32'sd0,       CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STEP, 16'sh8000,  1'b0, 32'sd0,       CSR_GAIN_MODE, '0},
      // all gains at the positive extreme, integral driven through both clamps
      '{ROW_CSR, REQ_STEP, 16'sd0,     1'b0, 32'sd0,       CSR_GAINS_NORMAL, 48'h7fff_7fff_7fff},
      '{ROW_CSR, REQ_STEP, 16'sd0,     1'b0, 32'sd0,       CSR_GAIN_MODE, 48'(MODE_NORMAL)},
      '{ROW_REQ, REQ_STEP, 16'sd2000,  1'b0, 32'sd0,       CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STEP, 16'sd2000,  1'b0, 32'sd0,       CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STEP, -16'sd5000, 1'b0, 32'sd0,       CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STEP, 16'sh7fff,  1'b0, 32'sd0,       CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STEP, 16'sh8000,  1'b0, 32'sd0,       CSR_GAIN_MODE, '0},
      // all gains at the negative extreme
      '{ROW_CSR, REQ_STEP, 16'sd0,     1'b0, 32'sd0,       CSR_GAINS_NORMAL, 48'h8000_8000_8000},
      '{ROW_REQ, REQ_STEP, 16'sh7fff,  1'b0, 32'sd0,       CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STEP, 16'sh8000,  1'b0, 32'sd0,       CSR_GAIN_MODE, '0},
      '{ROW_REQ, REQ_STEP, -16'sd1,    1'b0, 32'sd0,       CSR_GAIN_MODE, '0}
   };

   // ---------------------------------------------------------------
   // request side: directed table, then random phases
   // ---------------------------------------------------------------
   initial begin : stimulus
      int bias;
      wait (!reset);
      @(posedge clock);

      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_CSR) begin
            write_csr(dir_table[i].csr_idx, dir_table[i].csr_data);
         end else begin
            send_req(dir_table[i].rtype, dir_table[i].err,
                     dir_table[i].has_drive, dir_table[i].drive);
         end
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         // every fourth phase runs back to back on both sides
         calm = (ph % 4 == 3);
         // gain sets first, then the mode; the first phase rewrites them all
         if (ph == 0 || $urandom_range(0, 1) == 1)
            write_csr(CSR_GAINS_NORMAL, {pick_gain(), pick_gain(), pick_gain()});
         if (ph == 0 || $urandom_range(0, 1) == 1)
            write_csr(CSR_GAINS_LINE, {pick_gain(), pick_gain(), pick_gain()});
         if (ph == 0 || $urandom_range(0, 1) == 1)
            write_csr(CSR_GAINS_CIRCLE, {pick_gain(), pick_gain(), pick_gain()});
         // all four modes in the first phases, random after that
         write_csr(CSR_GAIN_MODE, (ph < 4) ? 48'(ph) : 48'($urandom_range(0, 3)));
         // a drift per phase pushes the integral toward one clamp or the other
         case ($urandom_range(0, 2))
            0:       bias = -200;
            1:       bias = 200;
            default: bias = 0;
         endcase
         random_phase = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 9) == 0)
               send_req(REQ_STOP, 16'($urandom()), 1'b0, '0);
            else
               send_req(REQ_STEP, pick_error(bias), 1'b0, '0);
         end
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request transactions (%0d stops), %0d csr writes, %0d phases",
               sent_count, stop_count, csr_count, RAND_PHASES);
      $display("checked %0d responses; integral clamped %0d high, %0d low; %0d hold-offs",
               checked_count, clamp_hi, clamp_lo, hold_count);
      if (fail_count == 0 && pending_drive.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // response side: random stall, long hold-offs, checker
   // ---------------------------------------------------------------

   // long hold-offs while requests keep coming, so both stages fill and
   // the block stalls its request channel
   initial begin : pressure
      wait (random_phase);
      repeat (20) @(posedge clock);
      repeat (2) begin
         hold_rsp <= 1'b1;
         hold_count++;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_rsp <= 1'b0;
         repeat ($urandom_range(500, 2500)) @(posedge clock);
      end
   end

   int stall_left = 0;

   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else begin
         // start a new stall now and then, its length from the gap mix
         if (stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = pick_gap();
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // every taken response must match the oldest expected drive value
   always @(posedge clock) begin : rsp_check
      logic signed [31:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_drive.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: response transaction with none pending, drive_value %0d",
                        $realtime, rsp_drive_value);
         end else begin
            want = pending_drive.pop_front();
            checked_count++;
            if (rsp_drive_value !== want) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: drive_value mismatch, expected %0d got %0d",
                           $realtime, want, rsp_drive_value);
            end
         end
      end
   end

   // hard stop if the run hangs
   initial begin : watchdog
      #TIMEOUT_NS;
      $display("TB_ERROR");
      $finish;
   end

endmodule
